[rtl/distinct_prime_factor_count_unit_macros.svh]
// Assertion macros used by the checker file of the distinct prime factor count unit.
`ifndef DISTINCT_PRIME_FACTOR_COUNT_UNIT_MACROS_SVH
`define DISTINCT_PRIME_FACTOR_COUNT_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPFC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DPFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/dpfc_pkg.sv]
// Package with the constants and the sequencer state type of the prime factor counter.
`default_nettype none
package dpfc_pkg;

  localparam int IN_BITS    = 32;
  localparam int COUNT_BITS = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_WAIT,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

[rtl/dpfc_if.sv]
// Valid/ready channel interfaces for the number items and the count items.
`default_nettype none
interface dpfc_num_if;
  logic                         valid;
  logic                         ready;
  logic [dpfc_pkg::IN_BITS-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface dpfc_cnt_if;
  logic                            valid;
  logic                            ready;
  logic [dpfc_pkg::COUNT_BITS-1:0] factor_count;

  modport source (output valid, output factor_count, input ready);
  modport sink (input valid, input factor_count, output ready);
endinterface
`default_nettype wire

[rtl/distinct_prime_factor_count_unit.sv]
// Top level: counts the distinct prime factors of a number by trial division.
//
//   channel   direction  payload                  handshake
//   operand   in         number [31:0]            valid/ready
//   result    out        factor_count [3:0]       valid/ready
//
// Each trial divisor takes one run of the divider, which produces one quotient bit per cycle.
// An item needs trial divisors up to the square root of the number, fewer when the remainder
// reaches 1; inputs 0 and 1 skip trial division.
// The block takes no new item until the current one is finished.
// A finished count waits in the output register while the next item is accepted.
// Reset is synchronous and clears the sequencer and the output valid.
`default_nettype none
module distinct_prime_factor_count_unit #(
  parameter int NUMBER_BITS = 32
) (
  input wire logic    clk,
  input wire logic    rst,
  dpfc_num_if.sink    operand,
  dpfc_cnt_if.source  result
);
  import dpfc_pkg::*;

  localparam int W  = NUMBER_BITS;
  localparam int DW = (W + 1) / 2 + 2;
  localparam int SW = W + 1;

  state_t state, state_next;

  logic [W-1:0]          n;
  logic [W-1:0]          rem;
  logic [DW-1:0]         d;
  logic [SW-1:0]         sq;
  logic [COUNT_BITS-1:0] cnt;
  logic                  hit;
  logic                  out_valid;
  logic [COUNT_BITS-1:0] out_count;

  logic [W-1:0]  n_in;
  logic          div_start;
  logic          div_done;
  logic [W-1:0]  quo;
  logic [DW-1:0] rmd;
  logic          too_big;
  logic          rem_one;
  logic          rmd_zero;
  logic          out_free;
  logic          take;
  logic          load_out;

  assign n_in     = W'(operand.number);
  assign too_big  = sq > {1'b0, n};
  assign rem_one  = rem == W'(1);
  assign rmd_zero = rmd == '0;
  assign out_free = !out_valid || result.ready;
  assign take     = operand.valid && operand.ready;

  dpfc_div #(
    .NUMBER_BITS(W),
    .DIV_BITS   (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rem),
    .divisor  (d),
    .done     (div_done),
    .quotient (quo),
    .remainder(rmd)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (operand.valid) begin
          state_next = (n_in < W'(2)) ? ST_FINISH : ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = too_big ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (rmd_zero) begin
            state_next = ST_DIV;
          end else if (rem_one) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    operand.ready = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE:   operand.ready = 1'b1;
      ST_DIV:    div_start     = 1'b1;
      ST_FINISH: load_out      = out_free;
      default: begin
        operand.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && take) begin
      n   <= n_in;
      rem <= n_in;
      d   <= DW'(2);
      sq  <= SW'(4);
      cnt <= '0;
      hit <= 1'b0;
    end else if (state == ST_CHECK && too_big) begin
      cnt <= cnt + COUNT_BITS'(1);
    end else if (state == ST_WAIT && div_done) begin
      if (rmd_zero) begin
        if (!hit) begin
          cnt <= cnt + COUNT_BITS'(1);
        end
        hit <= 1'b1;
        rem <= quo;
      end else if (!rem_one) begin
        hit <= 1'b0;
        if (d == DW'(2)) begin
          d  <= DW'(3);
          sq <= SW'(9);
        end else begin
          d  <= d + DW'(2);
          sq <= sq + (SW'(d) << 2) + SW'(4);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_count <= cnt;
    end
  end

  assign result.valid        = out_valid;
  assign result.factor_count = out_count;
endmodule
`default_nettype wire

[rtl/dpfc_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module dpfc_div #(
  parameter int NUMBER_BITS = 32,
  parameter int DIV_BITS    = 18
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [NUMBER_BITS-1:0] dividend,
  input  wire logic [DIV_BITS-1:0]    divisor,
  output logic                        done,
  output logic [NUMBER_BITS-1:0]      quotient,
  output logic [DIV_BITS-1:0]         remainder
);
  localparam int CW = $clog2(NUMBER_BITS + 1);

  logic [DIV_BITS-1:0]    acc;
  logic [NUMBER_BITS-1:0] quo;
  logic [DIV_BITS-1:0]    dv;
  logic [CW-1:0]          steps;
  logic                   running;
  logic [DIV_BITS:0]      trial;
  logic [DIV_BITS:0]      diff;
  logic                   fits;

  assign trial = {acc, quo[NUMBER_BITS-1]};
  assign diff  = trial - {1'b0, dv};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= CW'(NUMBER_BITS);
      end else if (running) begin
        steps <= steps - CW'(1);
        if (steps == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      quo <= dividend;
      dv  <= divisor;
    end else if (running) begin
      acc <= fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      quo <= {quo[NUMBER_BITS-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = acc;
endmodule
`default_nettype wire

[rtl/dpfc_chk.sv]
// Port-level checker for the prime factor counter and its bind to the top level.
`default_nettype none
`include "distinct_prime_factor_count_unit_macros.svh"
module dpfc_chk (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [dpfc_pkg::COUNT_BITS-1:0] factor_count
);
  // The block is not ready in the cycle after it accepts an item.
  `DPFC_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)

  // A new result is only loaded while the block is not taking items.
  `DPFC_ASSERT_SAME(a_load_while_busy, clk, rst, $rose(out_valid), !$past(in_ready))

  // A stalled result stays and keeps its value.
  `DPFC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(factor_count))
endmodule

bind distinct_prime_factor_count_unit dpfc_chk u_dpfc_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (operand.valid),
  .in_ready    (operand.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .factor_count(result.factor_count)
);
`default_nettype wire
